@@ sv/vos_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the order slicer.
package vos_pkg;

	localparam int BUCKET_DEPTH_DEF = 64;
	localparam int SLICE_SLOTS_DEF  = 64;
	localparam int CFG_IDX_W        = 4;

	localparam logic [1:0] OP_ARM  = 2'd0;
	localparam logic [1:0] OP_REQ  = 2'd1;
	localparam logic [1:0] OP_FILL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_TIME   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_TIME     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_QTY    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SLICE    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SLICE    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PART_Q16     = 4'd7;

	typedef struct packed {
		logic [1:0]  op;
		logic [62:0] now;
		logic [31:0] quote_price;
		logic        order_side;
		logic [31:0] leaves_qty;
		logic [31:0] order_filled_qty;
		logic [31:0] fill_qty;
	} in_item_t;

	typedef struct packed {
		logic        issued;
		logic [31:0] slice_number;
		logic [31:0] slice_qty;
		logic [31:0] slice_price;
		logic        slice_side;
		logic [5:0]  slot;
	} result_t;

	typedef struct packed {
		logic        go;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

endpackage

@@ sv/vos_div.sv @@
`timescale 1ns / 1ps
// Restoring 64/64 unsigned divider, one quotient bit per cycle.
module vos_div import vos_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[63]};
	assign fits  = trial >= {1'b0, req.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				rem_q  <= '0;
				quo_q  <= req.dividend;
				cnt_q  <= 7'd64;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= 64'(trial - {1'b0, req.divisor});
				end else begin
					rem_q <= trial[63:0];
				end
				quo_q <= {quo_q[62:0], fits};
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ sv/vwap_order_slicer_top.sv @@
`timescale 1ns / 1ps
// Time-bucketed VWAP order slicer: one item in, one result out, one item at a time.
// Item flow: a fill reads and rewrites the done entry of the current bucket; a slice
// request runs the bucket locate divide, then a prefix walk over the target memory
// up to the current bucket; an arm sums the bucket weights and divides the duration
// into the bucket span, then sends the target of each bucket below the last one in
// use through the shared divider and writes every other bucket store entry
// directly. Results sit in an output register, so the next item is taken while a
// result waits.
module vwap_order_slicer_top import vos_pkg::*; #(
	parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
	parameter int SLICE_SLOTS  = SLICE_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output result_t              out_item
);

	localparam int BW  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int NW  = $clog2(BUCKET_DEPTH + 1);
	localparam int SW  = (SLICE_SLOTS > 1) ? $clog2(SLICE_SLOTS) : 1;
	localparam int WW  = 2 * BW + 2;
	localparam int WSW = WW + BW + 1;
	localparam int PW  = 32 + BW;

	typedef enum logic [4:0] {
		S_IDLE, S_ARM_M2, S_ARM_SQ, S_ARM_ACC, S_ARM_SPAN, S_ARM_SPAN_W,
		S_TGT_SQ, S_TGT_MUL, S_TGT_DIV, S_TGT_WAIT, S_TGT_WR,
		S_REQ_LOC, S_REQ_LOC_W, S_REQ_INT, S_REQ_RD, S_PFX_RD, S_PFX_ACC,
		S_REQ_SIZE, S_REQ_MUL, S_REQ_SCALE, S_FILL_RD, S_FILL_WR, S_OUT
	} state_t;

	// configuration
	logic [6:0]  bcnt_q;
	logic [62:0] start_q, end_q, mint_q;
	logic [31:0] total_q, minq_q, maxq_q;
	logic [16:0] part_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q  <= '0;
			start_q <= '0;
			end_q   <= '0;
			total_q <= '0;
			mint_q  <= '0;
			minq_q  <= '0;
			maxq_q  <= '0;
			part_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BUCKET_COUNT: bcnt_q  <= cfg_data[6:0];
				REG_START_TIME:   start_q <= cfg_data[62:0];
				REG_END_TIME:     end_q   <= cfg_data[62:0];
				REG_TOTAL_QTY:    total_q <= cfg_data[31:0];
				REG_MIN_INTERVAL: mint_q  <= cfg_data[62:0];
				REG_MIN_SLICE:    minq_q  <= cfg_data[31:0];
				REG_MAX_SLICE:    maxq_q  <= cfg_data[31:0];
				REG_PART_Q16:     part_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	state_t            state_q;
	in_item_t          itm_q;
	result_t           res_q, out_q;
	logic              out_valid_q;
	logic              armed_q;
	logic [NW-1:0]     n_q;
	logic [BW-1:0]     m_q;
	logic [2*BW-1:0]   m2_q, d2_q;
	logic [62:0]       dur_q;
	logic [WSW-1:0]    wsum_q;
	logic [BW-1:0]     idx_q;
	logic [BW-1:0]     ab_q;
	logic [63:0]       span_q;
	logic [31:0]       assigned_q, tq_q;
	logic [63:0]       prod_q;
	logic [62:0]       last_q;
	logic [SW-1:0]     ring_q;
	logic [31:0]       num_q;
	logic [31:0]       rem_q, qs_q;
	logic [PW-1:0]     pfx_q;
	logic [BUCKET_DEPTH-1:0] done_vld_q;

	logic [31:0] tgt_mem  [BUCKET_DEPTH];
	logic [31:0] done_mem [BUCKET_DEPTH];
	logic [31:0] tgt_rd_q, done_rd_q;

	// divider
	div_req_t    dreq;
	logic        div_done;
	logic [63:0] div_quo;

	vos_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (dreq),
		.done     (div_done),
		.quotient (div_quo)
	);

	// weight terms
	logic [BW+1:0]   two_i, bm, dd;
	logic [BW-1:0]   d;
	logic [WW-1:0]   w_c;
	logic [62:0]     dur_c;
	logic [NW-1:0]   n_c;
	logic            last_i, before_last;
	logic [63:0]     n_m1;

	assign two_i = (BW + 2)'({idx_q, 1'b0});
	assign bm    = (BW + 2)'(m_q);
	assign dd    = (two_i >= bm) ? (two_i - bm) : (bm - two_i);
	assign d     = dd[BW-1:0];
	assign w_c   = WW'({m2_q, 1'b0}) + WW'(d2_q);
	assign dur_c = (end_q > start_q) ? (end_q - start_q) : 63'd1;
	assign n_c   = (32'(bcnt_q) > 32'(BUCKET_DEPTH)) ? NW'(BUCKET_DEPTH) : NW'(bcnt_q);
	assign before_last = (32'(idx_q) + 32'd1) < 32'(n_q);
	assign last_i      = (32'(idx_q) + 32'd1) == 32'(n_q);
	assign n_m1  = 64'(n_q) - 64'd1;

	always_comb begin
		dreq = '0;
		case (state_q)
			S_ARM_SPAN: begin
				dreq.go       = (n_q != '0);
				dreq.dividend = {1'b0, dur_q};
				dreq.divisor  = 64'(n_q);
			end
			S_ARM_SPAN_W: begin
				dreq.divisor  = 64'(n_q);
			end
			S_TGT_DIV, S_TGT_WAIT: begin
				dreq.go       = (state_q == S_TGT_DIV);
				dreq.dividend = prod_q;
				dreq.divisor  = 64'(wsum_q);
			end
			S_REQ_LOC, S_REQ_LOC_W: begin
				dreq.go       = (state_q == S_REQ_LOC);
				dreq.dividend = {1'b0, itm_q.now - start_q};
				dreq.divisor  = span_q;
			end
			default: ;
		endcase
	end

	// request checks and sizing
	logic          rej_c;
	logic [63:0]   gap_c;
	logic          too_soon;
	logic [31:0]   done_now;
	logic [PW-1:0] deficit;
	logic [31:0]   q1, q2, q3;
	logic [52:0]   x10;
	logic [36:0]   scaled;
	logic [31:0]   q4, q5;
	logic [32:0]   fsum;

	assign rej_c = !armed_q || (in_item.leaves_qty == '0) ||
		(in_item.now < start_q) || (in_item.now > end_q);
	assign gap_c    = {1'b0, itm_q.now} - {1'b0, last_q};
	assign too_soon = (last_q != '0) && (gap_c < {1'b0, mint_q});
	assign done_now = done_vld_q[ab_q] ? done_rd_q : 32'd0;

	always_comb begin
		deficit = (pfx_q > PW'(itm_q.order_filled_qty)) ?
			(pfx_q - PW'(itm_q.order_filled_qty)) : '0;
		if (deficit != '0) begin
			q1 = (deficit < PW'(maxq_q)) ? deficit[31:0] : maxq_q;
		end else begin
			q1 = (rem_q < maxq_q) ? rem_q : maxq_q;
		end
		q2 = (q1 > minq_q) ? q1 : minq_q;
		q3 = (q2 < itm_q.leaves_qty) ? q2 : itm_q.leaves_qty;
		x10    = {prod_q[49:0], 3'b000} + 53'({prod_q[49:0], 1'b0});
		scaled = x10[52:16];
		q4 = (scaled < 37'(maxq_q)) ? scaled[31:0] : maxq_q;
		q5 = (q4 < itm_q.leaves_qty) ? q4 : itm_q.leaves_qty;
		fsum = {1'b0, done_now} + {1'b0, itm_q.fill_qty};
	end

	// memories
	logic [BW-1:0] tgt_raddr;
	logic          tgt_we, done_we;
	logic [31:0]   tgt_wdata, done_wdata;

	assign tgt_raddr = (state_q == S_PFX_RD) ? idx_q : ab_q;
	assign tgt_we    = (state_q == S_TGT_WR);
	assign done_we   = (state_q == S_FILL_WR);
	assign tgt_wdata = before_last ? tq_q :
		(last_i ? ((total_q > assigned_q) ? (total_q - assigned_q) : 32'd0) : 32'd0);
	assign done_wdata = fsum[32] ? 32'hFFFF_FFFF : fsum[31:0];

	always_ff @(posedge clk) begin
		if (tgt_we) begin
			tgt_mem[idx_q] <= tgt_wdata;
		end
		tgt_rd_q <= tgt_mem[tgt_raddr];
	end

	always_ff @(posedge clk) begin
		if (done_we) begin
			done_mem[ab_q] <= done_wdata;
		end
		done_rd_q <= done_mem[ab_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			itm_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			armed_q     <= 1'b0;
			n_q         <= '0;
			m_q         <= '0;
			m2_q        <= '0;
			d2_q        <= '0;
			dur_q       <= '0;
			wsum_q      <= '0;
			idx_q       <= '0;
			ab_q        <= '0;
			span_q      <= '0;
			assigned_q  <= '0;
			tq_q        <= '0;
			prod_q      <= '0;
			last_q      <= '0;
			ring_q      <= '0;
			num_q       <= 32'd1;
			rem_q       <= '0;
			qs_q        <= '0;
			pfx_q       <= '0;
			done_vld_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						itm_q <= in_item;
						res_q <= '0;
						case (in_item.op)
							OP_ARM: begin
								n_q        <= n_c;
								m_q        <= BW'(n_c - NW'(1));
								dur_q      <= dur_c;
								done_vld_q <= '0;
								ab_q       <= '0;
								last_q     <= '0;
								ring_q     <= '0;
								num_q      <= 32'd1;
								armed_q    <= 1'b1;
								wsum_q     <= '0;
								idx_q      <= '0;
								assigned_q <= '0;
								state_q    <= S_ARM_M2;
							end
							OP_REQ: begin
								if (rej_c) begin
									state_q <= S_OUT;
								end else if (span_q == '0 || n_q == '0) begin
									ab_q    <= '0;
									state_q <= S_REQ_INT;
								end else begin
									state_q <= S_REQ_LOC;
								end
							end
							OP_FILL: state_q <= S_FILL_RD;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_ARM_M2: begin
					m2_q    <= m_q * m_q;
					state_q <= (n_q == '0) ? S_ARM_SPAN : S_ARM_SQ;
				end
				S_ARM_SQ: begin
					d2_q    <= d * d;
					state_q <= S_ARM_ACC;
				end
				S_ARM_ACC: begin
					wsum_q <= wsum_q + WSW'(w_c);
					if (last_i) begin
						state_q <= S_ARM_SPAN;
					end else begin
						idx_q   <= idx_q + BW'(1);
						state_q <= S_ARM_SQ;
					end
				end
				S_ARM_SPAN: begin
					idx_q <= '0;
					if (n_q == '0) begin
						span_q  <= {1'b0, dur_q};
						state_q <= S_TGT_SQ;
					end else begin
						state_q <= S_ARM_SPAN_W;
					end
				end
				S_ARM_SPAN_W: begin
					if (div_done) begin
						span_q  <= div_quo;
						state_q <= S_TGT_SQ;
					end
				end
				S_TGT_SQ: begin
					d2_q    <= d * d;
					state_q <= before_last ? S_TGT_MUL : S_TGT_WR;
				end
				S_TGT_MUL: begin
					prod_q  <= 64'(total_q * w_c);
					state_q <= S_TGT_DIV;
				end
				S_TGT_DIV: state_q <= S_TGT_WAIT;
				S_TGT_WAIT: begin
					if (div_done) begin
						tq_q    <= div_quo[31:0];
						state_q <= S_TGT_WR;
					end
				end
				S_TGT_WR: begin
					if (before_last) begin
						assigned_q <= assigned_q + tq_q;
					end
					if (32'(idx_q) == BUCKET_DEPTH - 1) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + BW'(1);
						state_q <= S_TGT_SQ;
					end
				end
				S_REQ_LOC: state_q <= S_REQ_LOC_W;
				S_REQ_LOC_W: begin
					if (div_done) begin
						ab_q    <= (div_quo > n_m1) ? BW'(n_m1) : BW'(div_quo);
						state_q <= S_REQ_INT;
					end
				end
				S_REQ_INT: begin
					state_q <= too_soon ? S_OUT : S_REQ_RD;
				end
				S_REQ_RD: begin
					if (tgt_rd_q <= done_now) begin
						state_q <= S_OUT;
					end else begin
						rem_q   <= tgt_rd_q - done_now;
						pfx_q   <= '0;
						idx_q   <= '0;
						state_q <= S_PFX_RD;
					end
				end
				S_PFX_RD: state_q <= S_PFX_ACC;
				S_PFX_ACC: begin
					pfx_q <= pfx_q + PW'(tgt_rd_q);
					if (idx_q == ab_q) begin
						state_q <= S_REQ_SIZE;
					end else begin
						idx_q   <= idx_q + BW'(1);
						state_q <= S_PFX_RD;
					end
				end
				S_REQ_SIZE: begin
					qs_q    <= q3;
					state_q <= S_REQ_MUL;
				end
				S_REQ_MUL: begin
					prod_q  <= 64'(qs_q * part_q);
					state_q <= S_REQ_SCALE;
				end
				S_REQ_SCALE: begin
					if (q5 != '0) begin
						res_q.issued       <= 1'b1;
						res_q.slice_number <= num_q;
						res_q.slice_qty    <= q5;
						res_q.slice_price  <= itm_q.quote_price;
						res_q.slice_side   <= itm_q.order_side;
						res_q.slot         <= 6'(ring_q);
						ring_q  <= (32'(ring_q) == SLICE_SLOTS - 1) ? '0 : ring_q + SW'(1);
						num_q   <= num_q + 32'd1;
						last_q  <= itm_q.now;
					end
					state_q <= S_OUT;
				end
				S_FILL_RD: state_q <= S_FILL_WR;
				S_FILL_WR: begin
					done_vld_q[ab_q] <= 1'b1;
					state_q          <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
